>>> sv/lisc_pkg.sv
// shared types and constants for the longest increasing subsequence counter
package lisc_pkg;

  // subsequence counts are fixed at 64 bits and saturate
  localparam int unsigned CNT_W = 64;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // result beat layout
  localparam int unsigned OUT_LEN_W   = 9;
  localparam int unsigned OUT_DATA_W  = OUT_LEN_W + CNT_W + 2;
  localparam int unsigned OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - OUT_DATA_W;

  // control flags that travel with an item along the chain
  typedef struct packed {
    logic active;   // slot holds an item
    logic last;     // final element of the sequence
    logic placed;   // item has found its free cell
    logic own_sat;  // its own count saturated
    logic seq_sat;  // saturation seen anywhere in the sequence so far
  } ctl_t;

endpackage

>>> sv/lisc_cell.sv
// one chain cell: holds one stored element and updates the item passing by
module lisc_cell #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned LEN_W       = 9
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  lisc_pkg::ctl_t           up_ctl,
  input  logic [VALUE_WIDTH-1:0]   up_key,
  input  logic [LEN_W-1:0]         up_len,
  input  logic [lisc_pkg::CNT_W-1:0] up_cnt,
  input  logic [LEN_W-1:0]         up_blen,
  input  logic [lisc_pkg::CNT_W-1:0] up_bcnt,
  output lisc_pkg::ctl_t           dn_ctl,
  output logic [VALUE_WIDTH-1:0]   dn_key,
  output logic [LEN_W-1:0]         dn_len,
  output logic [lisc_pkg::CNT_W-1:0] dn_cnt,
  output logic [LEN_W-1:0]         dn_blen,
  output logic [lisc_pkg::CNT_W-1:0] dn_bcnt
);
  import lisc_pkg::*;

  // saturating add, flag in the top bit
  function automatic logic [CNT_W:0] sat_add(input logic [CNT_W-1:0] a,
                                             input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[CNT_W]) begin
      return {1'b1, CNT_MAX};
    end
    return {(s[CNT_W-1:0] == CNT_MAX), s[CNT_W-1:0]};
  endfunction

  // stored element
  logic                   valid_r;
  logic [VALUE_WIDTH-1:0] key_r;
  logic [LEN_W-1:0]       len_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   sat_r;

  ctl_t                   n_ctl;
  logic [LEN_W-1:0]       n_len;
  logic [CNT_W-1:0]       n_cnt;
  logic [LEN_W-1:0]       n_blen;
  logic [CNT_W-1:0]       n_bcnt;
  logic                   wr;
  logic                   clr;
  logic [LEN_W-1:0]       cand;
  logic [LEN_W-1:0]       bsrc_len;
  logic [CNT_W-1:0]       bsrc_cnt;
  logic [CNT_W:0]         own_sum;
  logic [CNT_W:0]         best_sum;

  assign cand     = LEN_W'(len_r + 1'b1);
  assign bsrc_len = valid_r ? len_r : up_len;
  assign bsrc_cnt = valid_r ? cnt_r : up_cnt;
  assign own_sum  = sat_add(up_cnt, cnt_r);
  assign best_sum = sat_add(up_bcnt, bsrc_cnt);

  // item update against this cell
  always_comb begin
    n_ctl  = up_ctl;
    n_len  = up_len;
    n_cnt  = up_cnt;
    n_blen = up_blen;
    n_bcnt = up_bcnt;
    wr     = 1'b0;
    clr    = 1'b0;
    if (up_ctl.active) begin
      if (valid_r) begin
        // earlier element: extend if strictly smaller
        if ($signed(up_key) > $signed(key_r)) begin
          if (cand > up_len) begin
            n_len = cand;
            n_cnt = cnt_r;
          end else if (cand == up_len) begin
            n_cnt         = own_sum[CNT_W-1:0];
            n_ctl.own_sat = up_ctl.own_sat | own_sum[CNT_W];
          end
        end
        n_ctl.seq_sat = up_ctl.seq_sat | sat_r;
        clr           = up_ctl.last;
      end else if (!up_ctl.placed) begin
        // first free cell: item is final here
        n_ctl.placed  = 1'b1;
        n_ctl.seq_sat = up_ctl.seq_sat | up_ctl.own_sat;
        wr            = !up_ctl.last;
      end
      // running best over stored elements, then the item itself
      if (valid_r || !up_ctl.placed) begin
        if (bsrc_len > up_blen) begin
          n_blen = bsrc_len;
          n_bcnt = bsrc_cnt;
        end else if (bsrc_len == up_blen) begin
          n_bcnt        = best_sum[CNT_W-1:0];
          n_ctl.seq_sat = n_ctl.seq_sat | best_sum[CNT_W];
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      dn_ctl  <= '0;
    end else if (adv) begin
      dn_ctl <= n_ctl;
      if (wr) begin
        valid_r <= 1'b1;
      end else if (clr) begin
        valid_r <= 1'b0;
      end
    end
  end

  // stored element payload
  always_ff @(posedge clk) begin
    if (adv && wr) begin
      key_r <= up_key;
      len_r <= up_len;
      cnt_r <= up_cnt;
      sat_r <= up_ctl.own_sat;
    end
  end

  // item payload to the next cell
  always_ff @(posedge clk) begin
    if (adv) begin
      dn_key  <= up_key;
      dn_len  <= n_len;
      dn_cnt  <= n_cnt;
      dn_blen <= n_blen;
      dn_bcnt <= n_bcnt;
    end
  end

endmodule

>>> sv/longest_increasing_subsequence_count.sv
// Results are registered as the last element leaves the chain; the chain length sets latency.
// One element per cycle while the input is not stalled: each element walks the chain of
// MAX_ELEMENTS cells, one cell a cycle, and stores itself in the first free cell.
// Input stalls only while a result reaches the chain end and the previous one is untaken.
// Synchronous reset clears cell valid bits, slot control flags, out_tvalid and the dropped flag.
// Cells are cleared by the last element of each sequence as it passes them.
module longest_increasing_subsequence_count #(
  parameter int unsigned MAX_ELEMENTS = 256,
  parameter int unsigned VALUE_WIDTH  = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    in_tdata,   // value, zero pad
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [lisc_pkg::OUT_TDATA_W-1:0]    out_tdata   // longest_length, sequence_count,
                                                          // count_saturated, too_long, zero pad
);
  import lisc_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_ELEMENTS + 1);

  // item slots along the chain, slot 0 is the input beat
  ctl_t                   ctl_s  [MAX_ELEMENTS+1];
  logic [VALUE_WIDTH-1:0] key_s  [MAX_ELEMENTS+1];
  logic [LEN_W-1:0]       len_s  [MAX_ELEMENTS+1];
  logic [CNT_W-1:0]       cnt_s  [MAX_ELEMENTS+1];
  logic [LEN_W-1:0]       blen_s [MAX_ELEMENTS+1];
  logic [CNT_W-1:0]       bcnt_s [MAX_ELEMENTS+1];

  logic                   adv;
  logic                   stall;
  ctl_t                   tail;
  logic [31:0]            tail_len_ext;

  logic                   out_valid_r;
  logic                   ovf_r;
  logic [OUT_LEN_W-1:0]   out_len_r;
  logic [CNT_W-1:0]       out_cnt_r;
  logic                   out_sat_r;
  logic                   out_long_r;

  // new element enters with length one and count one
  always_comb begin
    ctl_s[0]        = '0;
    ctl_s[0].active = in_tvalid;
    ctl_s[0].last   = in_tlast;
  end
  assign key_s[0]  = in_tdata[VALUE_WIDTH-1:0];
  assign len_s[0]  = LEN_W'(1);
  assign cnt_s[0]  = CNT_W'(1);
  assign blen_s[0] = '0;
  assign bcnt_s[0] = '0;

  // chain of cells
  for (genvar k = 0; k < MAX_ELEMENTS; k++) begin : g_cell
    lisc_cell #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .LEN_W      (LEN_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .up_ctl (ctl_s[k]),
      .up_key (key_s[k]),
      .up_len (len_s[k]),
      .up_cnt (cnt_s[k]),
      .up_blen(blen_s[k]),
      .up_bcnt(bcnt_s[k]),
      .dn_ctl (ctl_s[k+1]),
      .dn_key (key_s[k+1]),
      .dn_len (len_s[k+1]),
      .dn_cnt (cnt_s[k+1]),
      .dn_blen(blen_s[k+1]),
      .dn_bcnt(bcnt_s[k+1])
    );
  end

  // chain moves unless a result would be lost
  assign tail      = ctl_s[MAX_ELEMENTS];
  assign stall     = tail.active && tail.last && out_valid_r && !out_tready;
  assign adv       = !stall;
  assign in_tready = adv;

  assign tail_len_ext = 32'(blen_s[MAX_ELEMENTS]);

  // output register and dropped element flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      ovf_r       <= 1'b0;
    end else begin
      priority if (adv && tail.active && tail.last) begin
        out_valid_r <= 1'b1;
        ovf_r       <= 1'b0;
      end else begin
        if (out_tready) begin
          out_valid_r <= 1'b0;
        end
        if (adv && tail.active && !tail.placed) begin
          ovf_r <= 1'b1;
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (adv && tail.active && tail.last) begin
      out_len_r  <= tail_len_ext[OUT_LEN_W-1:0];
      out_cnt_r  <= bcnt_s[MAX_ELEMENTS];
      out_sat_r  <= tail.seq_sat;
      out_long_r <= ovf_r | !tail.placed;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_long_r, out_sat_r, out_cnt_r, out_len_r};

`ifndef NO_ASSERTIONS
  // input holds off only behind an untaken result
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without a pending result");

  // a last element at the chain end always yields a result beat
  a_tail_result: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && tail.active && tail.last) |=> out_tvalid)
    else $error("result beat missing after last element");

  // dropped element flag is cleared with each result
  a_ovf_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && tail.active && tail.last) |=> !ovf_r)
    else $error("dropped element flag not cleared at end of sequence");
`endif

endmodule

>>> verif/longest_increasing_subsequence_count_test.sv
// self-checking bench for the streamed longest increasing subsequence counter
module longest_increasing_subsequence_count_test;

  import lisc_pkg::*;

  localparam int unsigned MAX_ELEMS   = 256;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned IN_TDATA_W  = ((VAL_W + 7) / 8) * 8;
  localparam int unsigned DRAIN_WAIT  = MAX_ELEMS + 50;
  localparam int unsigned HOLD_CYCLES = 700;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ELEMS = 16;
  localparam int unsigned PHASE_RUN   = 12;
  localparam int unsigned PRESS_BURST = 20;
  localparam int unsigned PRESS_IDLE  = MAX_ELEMS + 40;
  localparam int unsigned SAT_PAIRS   = 65;
  localparam int unsigned DIR_ROWS    = 22;

  // one result beat, last field in the lowest bits
  typedef struct packed {
    logic                 too_long;
    logic                 saturated;
    logic [CNT_W-1:0]     count;
    logic [OUT_LEN_W-1:0] length;
  } lis_result_t;

  // directed stimulus row, with an optional hand-written result
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last;
    logic                    typed;
    logic [OUT_LEN_W-1:0]    length;
    logic [CNT_W-1:0]        count;
  } dir_row_t;

  logic                      clk        = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      in_tvalid  = 1'b0;
  logic                      in_tready;
  logic [IN_TDATA_W-1:0]     in_tdata   = '0;
  logic                      in_tlast   = 1'b0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]    out_tdata;

  // predictor state for the sequence in progress
  logic signed [VAL_W-1:0]   lis_vals [MAX_ELEMS];
  int unsigned               lis_lens [MAX_ELEMS];
  logic [CNT_W-1:0]          lis_cnts [MAX_ELEMS];
  int unsigned               lis_fill     = 0;
  int unsigned               best_len     = 0;
  logic [CNT_W-1:0]          best_cnt     = '0;
  bit                        sat_seen     = 1'b0;
  bit                        dropped_seen = 1'b0;

  lis_result_t               expected_results [$];
  lis_result_t               got_res, want_res;
  dir_row_t                  dir_rows [DIR_ROWS];

  int unsigned               gap_pct    = 0;
  int unsigned               stall_pct  = 0;
  bit                        hold_on    = 1'b0;
  event                      hold_go;
  int unsigned               n_cycles   = 0;
  int unsigned               n_elements = 0;
  int unsigned               n_seqs     = 0;
  int unsigned               n_results  = 0;
  int unsigned               n_err      = 0;
  int unsigned               n_sat      = 0;
  int unsigned               n_long     = 0;

  longest_increasing_subsequence_count #(
    .MAX_ELEMENTS (MAX_ELEMS),
    .VALUE_WIDTH  (VAL_W)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // value
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)    // longest_length, sequence_count, count_saturated, too_long
  );

  // clock, period 4
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // saturating count addition, marks the sequence as saturated
  function automatic logic [CNT_W-1:0] sat_sum(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[CNT_W] || s[CNT_W-1:0] == CNT_MAX) begin
      sat_seen = 1'b1;
      return CNT_MAX;
    end
    return s[CNT_W-1:0];
  endfunction

  function automatic dir_row_t mk_row(input logic signed [VAL_W-1:0] v, input bit l,
                                      input bit t, input int unsigned len,
                                      input logic [CNT_W-1:0] cnt);
    dir_row_t r;
    r.value  = v;
    r.last   = l;
    r.typed  = t;
    r.length = len[OUT_LEN_W-1:0];
    r.count  = cnt;
    return r;
  endfunction

  // fold one accepted element into the running subsequence tables
  task automatic absorb_element(input logic signed [VAL_W-1:0] v, input bit l,
                                output lis_result_t r);
    int unsigned len;
    logic [CNT_W-1:0] cnt;
    int unsigned k;
    r = '0;
    if (lis_fill < MAX_ELEMS) begin
      len = 1;
      cnt = 1;
      for (k = 0; k < lis_fill; k++) begin
        if (v > lis_vals[k]) begin
          if (lis_lens[k] + 1 > len) begin
            len = lis_lens[k] + 1;
            cnt = lis_cnts[k];
          end else if (lis_lens[k] + 1 == len) begin
            cnt = sat_sum(cnt, lis_cnts[k]);
          end
        end
      end
      lis_vals[lis_fill] = v;
      lis_lens[lis_fill] = len;
      lis_cnts[lis_fill] = cnt;
      lis_fill++;
      if (len > best_len) begin
        best_len = len;
        best_cnt = cnt;
      end else if (len == best_len) begin
        best_cnt = sat_sum(best_cnt, cnt);
      end
    end else begin
      dropped_seen = 1'b1;
    end
    if (l) begin
      r.length    = best_len[OUT_LEN_W-1:0];
      r.count     = best_cnt;
      r.saturated = sat_seen;
      r.too_long  = dropped_seen;
      lis_fill     = 0;
      best_len     = 0;
      best_cnt     = '0;
      sat_seen     = 1'b0;
      dropped_seen = 1'b0;
    end
  endtask

  // offer one element beat, with random gaps before it
  task automatic send_item(input logic signed [VAL_W-1:0] v, input bit l,
                           input bit typed, input lis_result_t typed_r);
    lis_result_t r;
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tlast  <= l;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    absorb_element(v, l, r);
    n_elements++;
    if (l) begin
      n_seqs++;
      if (r.saturated) n_sat++;
      if (r.too_long) n_long++;
      expected_results.insert(expected_results.size(), typed ? typed_r : r);
    end
  endtask

  // one random sequence, shape picked per run
  task automatic send_random_run(input int unsigned max_len);
    int unsigned n, mode, k;
    logic signed [VAL_W-1:0] v;
    mode = $urandom_range(9);
    n = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
    if (n > max_len) n = max_len;
    for (k = 0; k < n; k++) begin
      case (mode)
        0, 1, 2, 3: v = int'($urandom_range(8)) - 4;
        4, 5:       v = $urandom;
        6: begin
          v = $urandom_range(1) ? 32'sh7FFF_FFFF - int'($urandom_range(3))
                                : 32'sh8000_0000 + int'($urandom_range(3));
        end
        default:    v = int'(k * 3) + int'($urandom_range(4)) - 2;
      endcase
      send_item(v, k == n - 1, 1'b0, '0);
    end
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    out_tready <= !hold_on && ($urandom_range(99) >= stall_pct);
  end

  // long hold-off, counted here
  always begin
    @(hold_go);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on = 1'b0;
  end

  // result beats are taken at the next rising edge; compare at the falling one
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_res = lis_result_t'(out_tdata[OUT_DATA_W-1:0]);
      if (expected_results.size() == 0) begin
        n_err++;
        $display("%0t: result beat with none expected: len=%0d cnt=%0d sat=%0b long=%0b",
                 $time, got_res.length, got_res.count, got_res.saturated,
                 got_res.too_long);
      end else begin
        want_res = expected_results.pop_front();
        n_results++;
        if (got_res.length !== want_res.length || got_res.count !== want_res.count ||
            got_res.saturated !== want_res.saturated ||
            got_res.too_long !== want_res.too_long) begin
          n_err++;
          $display("%0t: mismatch: expected len=%0d cnt=%0d sat=%0b long=%0b,",
                   $time, want_res.length, want_res.count, want_res.saturated,
                   want_res.too_long,
                   " got len=%0d cnt=%0d sat=%0b long=%0b",
                   got_res.length, got_res.count, got_res.saturated,
                   got_res.too_long);
        end
      end
    end
  end

  // watchdog
  initial begin
    while (n_cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      n_cycles++;
    end
    $display("timeout after %0d cycles", n_cycles);
    $display("end of test: mismatches");
    $finish;
  end

  // main sequence
  initial begin
    lis_result_t typed_r;
    int unsigned i, k;

    // directed rows: extremes, equal values, decreasing runs, a textbook case
    dir_rows[0]  = mk_row(0, 1, 1, 1, 1);
    dir_rows[1]  = mk_row(32'sh8000_0000, 1, 1, 1, 1);
    dir_rows[2]  = mk_row(32'sh7FFF_FFFF, 1, 1, 1, 1);
    dir_rows[3]  = mk_row(32'sh8000_0000, 0, 0, 0, 0);
    dir_rows[4]  = mk_row(32'sh7FFF_FFFF, 1, 1, 2, 1);
    dir_rows[5]  = mk_row(32'sh7FFF_FFFF, 0, 0, 0, 0);
    dir_rows[6]  = mk_row(32'sh8000_0000, 1, 1, 1, 2);
    dir_rows[7]  = mk_row(5, 0, 0, 0, 0);
    dir_rows[8]  = mk_row(5, 1, 1, 1, 2);
    dir_rows[9]  = mk_row(1, 0, 0, 0, 0);
    dir_rows[10] = mk_row(3, 0, 0, 0, 0);
    dir_rows[11] = mk_row(5, 0, 0, 0, 0);
    dir_rows[12] = mk_row(4, 0, 0, 0, 0);
    dir_rows[13] = mk_row(7, 1, 1, 4, 2);
    dir_rows[14] = mk_row(-1, 0, 0, 0, 0);
    dir_rows[15] = mk_row(-2, 0, 0, 0, 0);
    dir_rows[16] = mk_row(-3, 1, 1, 1, 3);
    dir_rows[17] = mk_row(2, 0, 0, 0, 0);
    dir_rows[18] = mk_row(-7, 0, 0, 0, 0);
    dir_rows[19] = mk_row(2, 0, 0, 0, 0);
    dir_rows[20] = mk_row(9, 1, 0, 0, 0);
    dir_rows[21] = mk_row(-1, 1, 1, 1, 1);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < DIR_ROWS; i++) begin
      typed_r           = '0;
      typed_r.length    = dir_rows[i].length;
      typed_r.count     = dir_rows[i].count;
      send_item(dir_rows[i].value, dir_rows[i].last, dir_rows[i].typed, typed_r);
    end

    // strictly rising past capacity: longest length at its maximum, and the
    // final dropped element carries last
    for (k = 0; k < MAX_ELEMS + 2; k++)
      send_item(int'(k) - 128, k == MAX_ELEMS + 1, 1'b0, '0);
    // descending pairs double the count each step until it saturates
    for (k = 0; k < SAT_PAIRS; k++) begin
      send_item(int'(2 * k + 1), 1'b0, 1'b0, '0);
      send_item(int'(2 * k), k == SAT_PAIRS - 1, 1'b0, '0);
    end
    wait_drain();

    // random sequences under four idling mixes
    for (i = 0; i < 4; i++) begin
      case (i)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 48; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 48; end
        default: begin gap_pct = 18; stall_pct = 18; end
      endcase
      k = n_elements;
      while (n_elements - k < PHASE_ELEMS) send_random_run(PHASE_RUN);
      wait_drain();
    end

    // receiver held off: fill the chain, idle until results block it, then
    // keep offering short runs against the stalled input
    gap_pct   = 0;
    stall_pct = 0;
    -> hold_go;
    k = n_elements;
    while (n_elements - k < PRESS_BURST) send_random_run(4);
    in_tvalid <= 1'b0;
    repeat (PRESS_IDLE) @(posedge clk);
    k = n_elements;
    while (n_elements - k < PRESS_BURST) send_random_run(4);
    wait_drain();

    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d elements in %0d sequences (%0d saturating, %0d over capacity)",
             n_elements, n_seqs, n_sat, n_long);
    $display("checked %0d results under mixed idling and a long output hold-off", n_results);
    if (n_err == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", n_err);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> files.f
sv/lisc_pkg.sv
sv/lisc_cell.sv
sv/longest_increasing_subsequence_count.sv
verif/longest_increasing_subsequence_count_test.sv
